FILE: rtl/tacs_pkg.sv
// Shared types, constants and the climb step table for the two-axis climb sequencer.
// No dependencies; every other file in rtl/ imports this package.
`timescale 1ns / 1ps

package tacs_pkg;

    // Width of a potentiometer reading and of a position threshold
    localparam int POS_W   = 10;
    // Width of a motor command in hundredths
    localparam int DRIVE_W = 8;
    localparam int STEP_W  = 4;
    localparam int CFG_W   = 10;
    localparam int CFG_IDX_W = 3;
    localparam int DEAD_W  = 7;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAST_UPPER  = 3'd0,
        REG_MAST_LOWER  = 3'd1,
        REG_TILT_FWD    = 3'd2,
        REG_TILT_BACK   = 3'd3,
        REG_DEADBAND    = 3'd4,
        REG_DOWN_TARGET = 3'd5,
        REG_UP_TARGET   = 3'd6
    } reg_index_t;

    // Register reset values
    localparam logic [POS_W-1:0]  MAST_UPPER_RST  = 10'd136;
    localparam logic [POS_W-1:0]  MAST_LOWER_RST  = 10'd960;
    localparam logic [POS_W-1:0]  TILT_FWD_RST    = 10'd630;
    localparam logic [POS_W-1:0]  TILT_BACK_RST   = 10'd430;
    localparam logic [DEAD_W-1:0] DEADBAND_RST    = 7'd10;
    localparam logic [POS_W-1:0]  DOWN_TARGET_RST = 10'd430;
    localparam logic [POS_W-1:0]  UP_TARGET_RST   = 10'd483;

    // Motor commands
    localparam logic signed [DRIVE_W-1:0] DRIVE_FWD_FULL = 8'sd100;
    localparam logic signed [DRIVE_W-1:0] DRIVE_FWD_70   = 8'sd70;
    localparam logic signed [DRIVE_W-1:0] DRIVE_FWD_50   = 8'sd50;
    localparam logic signed [DRIVE_W-1:0] DRIVE_FWD_20   = 8'sd20;
    localparam logic signed [DRIVE_W-1:0] DRIVE_STOP     = 8'sd0;
    localparam logic signed [DRIVE_W-1:0] DRIVE_REV_FULL = -8'sd100;
    localparam logic signed [DRIVE_W-1:0] DRIVE_REV_70   = -8'sd70;
    localparam logic signed [DRIVE_W-1:0] DRIVE_REV_50   = -8'sd50;
    localparam logic signed [DRIVE_W-1:0] DRIVE_REV_20   = -8'sd20;

    // Preset bang-bang thresholds
    localparam logic [POS_W-1:0] PRESET_TILT_DOWN = 10'd486;
    localparam logic [POS_W-1:0] PRESET_MAST_UP   = 10'd610;
    localparam logic [POS_W-1:0] PRESET_TILT_UP   = 10'd477;
    localparam logic [POS_W-1:0] PRESET_TILT_LOW  = 10'd513;

    // Last climb step; the sequence is finished at this value
    localparam logic [STEP_W-1:0] STEP_DONE = 4'd10;

    typedef struct packed {
        logic [10:0]               climber_buttons;
        logic [1:0]                shooter_buttons;
        logic signed [DRIVE_W-1:0] tilt_stick;
        logic [POS_W-1:0]          tilt_position;
        logic [POS_W-1:0]          mast_position;
    } in_item_t;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] mast_drive;
        logic signed [DRIVE_W-1:0] tilt_drive;
        logic                      shooter_stow;
        logic [STEP_W-1:0]         sequence_step_out;
    } out_item_t;

    typedef struct packed {
        logic [POS_W-1:0]  mast_upper_limit;
        logic [POS_W-1:0]  mast_lower_limit;
        logic [POS_W-1:0]  tilt_forward_limit;
        logic [POS_W-1:0]  tilt_back_limit;
        logic [DEAD_W-1:0] stick_deadband;
        logic [POS_W-1:0]  drive_down_target;
        logic [POS_W-1:0]  drive_up_target;
    } cfg_t;

    typedef struct packed {
        logic [STEP_W-1:0]         step;
        logic signed [DRIVE_W-1:0] mast_drive;
        logic signed [DRIVE_W-1:0] tilt_drive;
    } state_t;

    // One climb step: which axis, compare sense, threshold
    typedef struct packed {
        logic             valid;
        logic             is_mast;
        logic             less;     // keep driving while position < limit (reverse drive)
        logic [POS_W-1:0] limit;
    } seq_entry_t;

    function automatic seq_entry_t seq_entry(input logic [STEP_W-1:0] step);
        seq_entry_t e;
        e = '0;
        unique case (step)
            4'd0:    e = '{1'b1, 1'b1, 1'b1, 10'd964};
            4'd1:    e = '{1'b1, 1'b0, 1'b1, 10'd526};
            4'd2:    e = '{1'b1, 1'b1, 1'b0, 10'd927};
            4'd3:    e = '{1'b1, 1'b0, 1'b1, 10'd562};
            4'd4:    e = '{1'b1, 1'b1, 1'b0, 10'd126};
            4'd5:    e = '{1'b1, 1'b0, 1'b0, 10'd542};
            4'd6:    e = '{1'b1, 1'b1, 1'b1, 10'd815};
            4'd7:    e = '{1'b1, 1'b0, 1'b0, 10'd510};
            4'd8:    e = '{1'b1, 1'b1, 1'b1, 10'd963};
            4'd9:    e = '{1'b1, 1'b0, 1'b1, 10'd529};
            default: e = '0;
        endcase
        return e;
    endfunction

endpackage

FILE: rtl/tacs_cfg_regs.sv
// Config register file: decodes writes into the limit, deadband and target registers.
// Depends on tacs_pkg.
`timescale 1ns / 1ps

module tacs_cfg_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [tacs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tacs_pkg::CFG_W-1:0]      cfg_wdata,
    output tacs_pkg::cfg_t                  cfg
);
    import tacs_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Write decode; an index past the list leaves everything alone
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (reg_index_t'(cfg_index))
                REG_MAST_UPPER:  cfg_next.mast_upper_limit   = cfg_wdata;
                REG_MAST_LOWER:  cfg_next.mast_lower_limit   = cfg_wdata;
                REG_TILT_FWD:    cfg_next.tilt_forward_limit = cfg_wdata;
                REG_TILT_BACK:   cfg_next.tilt_back_limit    = cfg_wdata;
                REG_DEADBAND:    cfg_next.stick_deadband     = cfg_wdata[DEAD_W-1:0];
                REG_DOWN_TARGET: cfg_next.drive_down_target  = cfg_wdata;
                REG_UP_TARGET:   cfg_next.drive_up_target    = cfg_wdata;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mast_upper_limit   <= MAST_UPPER_RST;
            cfg_reg.mast_lower_limit   <= MAST_LOWER_RST;
            cfg_reg.tilt_forward_limit <= TILT_FWD_RST;
            cfg_reg.tilt_back_limit    <= TILT_BACK_RST;
            cfg_reg.stick_deadband     <= DEADBAND_RST;
            cfg_reg.drive_down_target  <= DOWN_TARGET_RST;
            cfg_reg.drive_up_target    <= UP_TARGET_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/tacs_tick.sv
// One control tick: priority chain over buttons, stick and positions, and the climb step.
// Combinational; depends on tacs_pkg.
`timescale 1ns / 1ps

module tacs_tick (
    input  tacs_pkg::cfg_t     cfg,
    input  tacs_pkg::in_item_t item,
    input  tacs_pkg::state_t   state,
    output tacs_pkg::out_item_t result
);
    import tacs_pkg::*;

    localparam int EXT_W = POS_W + 2;

    // Downward ramp: faster the further above the target
    function automatic logic signed [DRIVE_W-1:0] ramp_down(
        input logic [POS_W-1:0] pos,
        input logic [POS_W-1:0] tgt
    );
        logic [EXT_W-1:0] p;
        logic [EXT_W-1:0] t;
        logic signed [DRIVE_W-1:0] d;
        p = {2'b00, pos};
        t = {2'b00, tgt};
        if (p > t + EXT_W'(30))      d = DRIVE_FWD_FULL;
        else if (p > t + EXT_W'(20)) d = DRIVE_FWD_70;
        else if (p > t + EXT_W'(10)) d = DRIVE_FWD_50;
        else if (p > t)              d = DRIVE_FWD_20;
        else                         d = DRIVE_STOP;
        return d;
    endfunction

    // Upward ramp; pos < t - k is written as pos + k < t to stay unsigned
    function automatic logic signed [DRIVE_W-1:0] ramp_up(
        input logic [POS_W-1:0] pos,
        input logic [POS_W-1:0] tgt
    );
        logic [EXT_W-1:0] p;
        logic [EXT_W-1:0] t;
        logic signed [DRIVE_W-1:0] d;
        p = {2'b00, pos};
        t = {2'b00, tgt};
        if (p + EXT_W'(30) < t)      d = DRIVE_REV_FULL;
        else if (p + EXT_W'(20) < t) d = DRIVE_REV_70;
        else if (p + EXT_W'(10) < t) d = DRIVE_REV_50;
        else if (p < t)              d = DRIVE_REV_20;
        else                         d = DRIVE_STOP;
        return d;
    endfunction

    logic [10:0]               cb;
    logic [POS_W-1:0]          tilt;
    logic [POS_W-1:0]          mast;
    logic signed [DRIVE_W:0]   stick_w;
    logic signed [DRIVE_W:0]   dead_w;
    logic signed [DRIVE_W-1:0] stick_sat;
    logic [STEP_W-1:0]         step_base;
    seq_entry_t                entry;
    logic [POS_W-1:0]          seq_pos;
    logic                      seq_keep;
    logic signed [DRIVE_W-1:0] seq_speed;

    assign cb   = item.climber_buttons;
    assign tilt = item.tilt_position;
    assign mast = item.mast_position;

    // Stick against deadband, one bit wider so the negation cannot wrap
    assign stick_w = {item.tilt_stick[DRIVE_W-1], item.tilt_stick};
    assign dead_w  = $signed({2'b00, cfg.stick_deadband});

    always_comb begin
        if (item.tilt_stick > DRIVE_FWD_FULL)      stick_sat = DRIVE_FWD_FULL;
        else if (item.tilt_stick < DRIVE_REV_FULL) stick_sat = DRIVE_REV_FULL;
        else                                       stick_sat = item.tilt_stick;
    end

    // Climber button 9 restarts the sequence before anything else looks at it
    assign step_base = cb[8] ? '0 : state.step;

    // Current climb step decode
    assign entry     = seq_entry(step_base);
    assign seq_pos   = entry.is_mast ? mast : tilt;
    assign seq_keep  = entry.less ? (seq_pos < entry.limit) : (seq_pos > entry.limit);
    assign seq_speed = entry.less ? DRIVE_REV_FULL : DRIVE_FWD_FULL;

    // Priority chain, first match wins; unwritten drives hold
    always_comb begin
        result.mast_drive        = state.mast_drive;
        result.tilt_drive        = state.tilt_drive;
        result.shooter_stow      = 1'b0;
        result.sequence_step_out = step_base;
        if (cb[2] && mast > cfg.mast_upper_limit) begin
            result.mast_drive = DRIVE_FWD_FULL;
        end else if (cb[1] && mast < cfg.mast_lower_limit) begin
            result.mast_drive = DRIVE_REV_FULL;
        end else if (item.shooter_buttons[0]) begin
            result.tilt_drive = ramp_down(tilt, cfg.drive_down_target);
        end else if (item.shooter_buttons[1]) begin
            result.tilt_drive = ramp_up(tilt, cfg.drive_up_target);
        end else if (stick_w < -dead_w && tilt < cfg.tilt_forward_limit) begin
            result.tilt_drive = stick_sat;
        end else if (stick_w > dead_w && tilt > cfg.tilt_back_limit) begin
            result.tilt_drive = stick_sat;
        end else if (cb[5]) begin
            result.tilt_drive = (tilt < PRESET_TILT_DOWN) ? DRIVE_REV_FULL : DRIVE_STOP;
        end else if (cb[6]) begin
            result.mast_drive = (mast > PRESET_MAST_UP) ? DRIVE_FWD_FULL : DRIVE_STOP;
        end else if (cb[9]) begin
            result.tilt_drive = (tilt > PRESET_TILT_UP) ? DRIVE_FWD_FULL : DRIVE_STOP;
        end else if (cb[10]) begin
            result.tilt_drive = (tilt < PRESET_TILT_LOW) ? DRIVE_REV_FULL : DRIVE_STOP;
        end else if (cb[7]) begin
            if (entry.valid) begin
                // step 0 stows the shooter as it lowers the mast
                result.shooter_stow = (step_base == '0);
                if (entry.is_mast) begin
                    result.mast_drive = seq_keep ? seq_speed : DRIVE_STOP;
                end else begin
                    result.tilt_drive = seq_keep ? seq_speed : DRIVE_STOP;
                end
                if (!seq_keep) begin
                    result.sequence_step_out = step_base + STEP_W'(1);
                end
            end else begin
                // sequence finished: both motors stop, step stays
                result.mast_drive = DRIVE_STOP;
                result.tilt_drive = DRIVE_STOP;
            end
        end else begin
            result.mast_drive = DRIVE_STOP;
            result.tilt_drive = DRIVE_STOP;
        end
    end

endmodule

FILE: rtl/two_axis_climb_sequencer_top.sv
// Top level of the two-axis climb sequencer: input register, tick logic, result register.
// Depends on tacs_pkg, tacs_cfg_regs and tacs_tick.
//
//  Port group   Dir  Handshake        Payload
//  s_*          in   s_valid/s_ready  s_data  (tacs_pkg::in_item_t)
//  m_*          out  m_valid/m_ready  m_data  (tacs_pkg::out_item_t)
//  cfg_*        in   cfg_we           cfg_index, cfg_wdata
//
// One request per cycle sustained while m_ready stays high; each request is held
// in the input register and then computed into the result register. The step and
// held drives update as a request moves into the result register. A stalled
// result holds the result register; the input register still takes one more
// request. Synchronous active-low reset restores register defaults and clears
// step and drives.
`timescale 1ns / 1ps

module two_axis_climb_sequencer_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  tacs_pkg::in_item_t              s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output tacs_pkg::out_item_t             m_data,
    input  logic                            cfg_we,
    input  logic [tacs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tacs_pkg::CFG_W-1:0]      cfg_wdata
);
    import tacs_pkg::*;

    cfg_t      cfg;
    in_item_t  in_data_reg;
    logic      in_valid_reg;
    out_item_t out_data_reg;
    logic      out_valid_reg;
    state_t    state_reg;
    state_t    state_next;
    out_item_t tick_result;
    logic      advance;

    tacs_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    tacs_tick u_tick (
        .cfg    (cfg),
        .item   (in_data_reg),
        .state  (state_reg),
        .result (tick_result)
    );

    // Pipeline control: the input stage moves on whenever the result slot frees
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    assign state_next.step       = tick_result.sequence_step_out;
    assign state_next.mast_drive = tick_result.mast_drive;
    assign state_next.tilt_drive = tick_result.tilt_drive;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    // Result register and sequencer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end else begin
            if (advance) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= tick_result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule
